// ===== rtl/rac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Admission control package
// Shared types and constants of the admission control core.
// ----------------------------------------------------------------------------
package rac_pkg;
    localparam int HASH_W    = 256;
    localparam int WORD_W    = 64;
    localparam int OP_W      = 3;
    localparam int VERDICT_W = 3;
    localparam int QCOUNT_W  = 7;
    localparam int FCOUNT_W  = 4;
    localparam int CREDIT_W  = 24;
    localparam int PERIOD_W  = 16;
    localparam int BURST_W   = 8;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [OP_W-1:0] OP_ADMIT  = 3'd0;
    localparam logic [OP_W-1:0] OP_START  = 3'd1;
    localparam logic [OP_W-1:0] OP_FINISH = 3'd2;
    localparam logic [OP_W-1:0] OP_TICK   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [VERDICT_W-1:0] V_ALLOW         = 3'd0;
    localparam logic [VERDICT_W-1:0] V_DUP           = 3'd1;
    localparam logic [VERDICT_W-1:0] V_INFLIGHT_FULL = 3'd2;
    localparam logic [VERDICT_W-1:0] V_QUEUE_FULL    = 3'd3;
    localparam logic [VERDICT_W-1:0] V_RATE          = 3'd4;
    localparam logic [VERDICT_W-1:0] V_NOT_ADMIT     = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_REFILL_PERIOD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_TOKENS  = 8'd1;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
    localparam logic [BURST_W-1:0]  BURST_RESET  = 8'd8;
    localparam logic [CREDIT_W-1:0] CREDIT_RESET = 24'd8000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_ACT
    } t_state;

    typedef struct packed {
        logic go;
        logic ins;
        logic rm;
        logic hit;
        logic claim;
    } t_link;
endpackage
`default_nettype wire

// ===== rtl/rac_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Carries one operation and its 256-bit job hash.
// ----------------------------------------------------------------------------
interface rac_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [63:0] hash_w0;
    logic [63:0] hash_w1;
    logic [63:0] hash_w2;
    logic [63:0] hash_w3;

    modport source (output valid, op, hash_w0, hash_w1, hash_w2, hash_w3, input ready);
    modport sink (input valid, op, hash_w0, hash_w1, hash_w2, hash_w3, output ready);
endinterface
`default_nettype wire

// ===== rtl/rac_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Carries the verdict, set occupancy and overflow flag of one request.
// ----------------------------------------------------------------------------
interface rac_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] verdict;
    logic [6:0] queued_count;
    logic [3:0] inflight_count;
    logic       overflow;

    modport source (output valid, verdict, queued_count, inflight_count, overflow,
                    input ready);
    modport sink (input valid, verdict, queued_count, inflight_count, overflow,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/rac_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and its write data.
// ----------------------------------------------------------------------------
interface rac_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/reverify_admission_control_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Re-verification admission control core
// Token bucket admission with queued and in-flight hash sets.
// ----------------------------------------------------------------------------
// Usage: requests enter on i_req (op and a 256-bit hash), one response per
// request leaves on o_rsp. Registers are written through i_cfg, which is
// always ready; writes are meant to happen while no request is in progress.
// Each set is a chain of slot cells. A request sends a search token down both
// chains, one cell per cycle, then decides and registers the response. Admit
// and start requests that store a hash send a second insert token down one
// chain. The next request can be taken after the decision or, for a stored
// hash, after its insert token reaches the end of its chain. One request is
// worked on at a time. The response register lets the next request be taken
// while a response still waits; a stalled receiver holds the core in its
// decision step.
// Reset empties both sets, loads the registers with a period of 1000 ticks and
// a burst of 8 tokens, and fills the bucket.
// ----------------------------------------------------------------------------
module reverify_admission_control_core
    import rac_pkg::*;
#(
    parameter int QUEUE_SLOTS    = 64,
    parameter int INFLIGHT_SLOTS = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rac_req_if.sink    i_req,
    rac_rsp_if.source  o_rsp,
    rac_cfg_if.sink    i_cfg
);
    localparam int QW = $clog2(QUEUE_SLOTS + 1);
    localparam int FW = $clog2(INFLIGHT_SLOTS + 1);

    t_state                r_state;
    t_state                n_state;
    logic [OP_W-1:0]       r_op;
    logic [HASH_W-1:0]     r_hash;
    logic                  r_launch;
    logic                  r_act_q;
    logic                  r_act_f;
    logic                  r_qdone;
    logic                  r_fdone;
    logic                  r_qhit;
    logic                  r_fhit;
    logic [QW-1:0]         r_qcnt;
    logic [QW-1:0]         n_qcnt;
    logic [FW-1:0]         r_fcnt;
    logic [FW-1:0]         n_fcnt;
    logic [CREDIT_W-1:0]   r_credit;
    logic [CREDIT_W-1:0]   n_credit;
    logic [PERIOD_W-1:0]   r_period;
    logic [BURST_W-1:0]    r_burst;
    logic                  r_out_valid;
    logic [VERDICT_W-1:0]  r_verdict;
    logic [VERDICT_W-1:0]  n_verdict;
    logic                  r_ovf;
    logic                  n_ovf;
    logic [QW-1:0]         r_out_qcnt;
    logic [FW-1:0]         r_out_fcnt;

    logic                  accept;
    logic                  fire;
    logic                  do_clear;
    logic                  act_q;
    logic                  act_f;
    logic                  q_full;
    logic                  f_full;
    logic [PERIOD_W-1:0]   period;
    logic [CREDIT_W-1:0]   cap;
    t_link                 q_link [0:QUEUE_SLOTS];
    t_link                 f_link [0:INFLIGHT_SLOTS];
    logic                  q_tail_search;
    logic                  f_tail_search;
    logic                  tail_ins;

    assign period = (r_period == '0) ? PERIOD_W'(1) : r_period;
    assign cap    = CREDIT_W'(r_burst) * CREDIT_W'(period);
    assign q_full = (r_qcnt == QW'(QUEUE_SLOTS));
    assign f_full = (r_fcnt == FW'(INFLIGHT_SLOTS));

    assign q_link[0] = '{go: r_launch | r_act_q, ins: r_act_q,
                         rm: (r_op == OP_START || r_op == OP_FINISH) && !r_act_q,
                         hit: 1'b0, claim: 1'b0};
    assign f_link[0] = '{go: r_launch | r_act_f, ins: r_act_f,
                         rm: (r_op == OP_FINISH) && !r_act_f,
                         hit: 1'b0, claim: 1'b0};

    for (genvar gi = 0; gi < QUEUE_SLOTS; gi++) begin : g_q
        rac_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (do_clear),
            .i_key   (r_hash),
            .i_link  (q_link[gi]),
            .o_link  (q_link[gi+1])
        );
    end

    for (genvar gi = 0; gi < INFLIGHT_SLOTS; gi++) begin : g_f
        rac_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (do_clear),
            .i_key   (r_hash),
            .i_link  (f_link[gi]),
            .o_link  (f_link[gi+1])
        );
    end

    assign q_tail_search = q_link[QUEUE_SLOTS].go && !q_link[QUEUE_SLOTS].ins;
    assign f_tail_search = f_link[INFLIGHT_SLOTS].go && !f_link[INFLIGHT_SLOTS].ins;
    assign tail_ins = (q_link[QUEUE_SLOTS].go && q_link[QUEUE_SLOTS].ins)
                   || (f_link[INFLIGHT_SLOTS].go && f_link[INFLIGHT_SLOTS].ins);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (r_qdone && r_fdone) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (fire) begin
                    n_state = (act_q || act_f) ? S_ACT : S_IDLE;
                end
            end
            S_ACT: begin
                if (tail_ins) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        accept = (r_state == S_IDLE) && i_req.valid;
        fire   = (r_state == S_DECIDE) && (!r_out_valid || o_rsp.ready);
    end

    always_comb begin
        n_verdict = V_NOT_ADMIT;
        n_ovf     = 1'b0;
        n_qcnt    = r_qcnt;
        n_fcnt    = r_fcnt;
        n_credit  = r_credit;
        act_q     = 1'b0;
        act_f     = 1'b0;
        do_clear  = 1'b0;
        if (fire) begin
            priority if (r_op == OP_ADMIT) begin
                priority if (r_qhit || r_fhit) begin
                    n_verdict = V_DUP;
                end else if (f_full) begin
                    n_verdict = V_INFLIGHT_FULL;
                end else if (q_full) begin
                    n_verdict = V_QUEUE_FULL;
                end else if (r_credit < CREDIT_W'(period)) begin
                    n_verdict = V_RATE;
                end else begin
                    n_verdict = V_ALLOW;
                    n_credit  = r_credit - CREDIT_W'(period);
                    n_qcnt    = r_qcnt + QW'(1);
                    act_q     = 1'b1;
                end
            end else if (r_op == OP_START) begin
                n_qcnt = r_qcnt - QW'(r_qhit);
                if (!r_fhit) begin
                    if (f_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_fcnt = r_fcnt + FW'(1);
                        act_f  = 1'b1;
                    end
                end
            end else if (r_op == OP_FINISH) begin
                n_qcnt = r_qcnt - QW'(r_qhit);
                n_fcnt = r_fcnt - FW'(r_fhit);
            end else if (r_op == OP_TICK) begin
                n_credit = (r_credit >= cap) ? cap : r_credit + CREDIT_W'(1);
            end else if (r_op == OP_CLEAR) begin
                n_credit = cap;
                n_qcnt   = '0;
                n_fcnt   = '0;
                do_clear = 1'b1;
            end else begin
                n_verdict = V_NOT_ADMIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch    <= 1'b0;
            r_act_q     <= 1'b0;
            r_act_f     <= 1'b0;
            r_qdone     <= 1'b0;
            r_fdone     <= 1'b0;
            r_qcnt      <= '0;
            r_fcnt      <= '0;
            r_credit    <= CREDIT_RESET;
            r_period    <= PERIOD_RESET;
            r_burst     <= BURST_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= accept;
            r_act_q  <= act_q;
            r_act_f  <= act_f;
            r_qcnt   <= n_qcnt;
            r_fcnt   <= n_fcnt;
            r_credit <= n_credit;
            if (accept) begin
                r_qdone <= 1'b0;
                r_fdone <= 1'b0;
            end else begin
                if (q_tail_search) begin
                    r_qdone <= 1'b1;
                end
                if (f_tail_search) begin
                    r_fdone <= 1'b1;
                end
            end
            if (i_cfg.valid && i_cfg.index == REG_REFILL_PERIOD) begin
                r_period <= i_cfg.data[PERIOD_W-1:0];
            end
            if (i_cfg.valid && i_cfg.index == REG_BURST_TOKENS) begin
                r_burst <= i_cfg.data[BURST_W-1:0];
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_req.op;
            r_hash <= {i_req.hash_w3, i_req.hash_w2, i_req.hash_w1, i_req.hash_w0};
        end
        if (q_tail_search) begin
            r_qhit <= q_link[QUEUE_SLOTS].hit;
        end
        if (f_tail_search) begin
            r_fhit <= f_link[INFLIGHT_SLOTS].hit;
        end
        if (fire) begin
            r_verdict  <= n_verdict;
            r_ovf      <= n_ovf;
            r_out_qcnt <= n_qcnt;
            r_out_fcnt <= n_fcnt;
        end
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign i_cfg.ready          = 1'b1;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.verdict        = r_verdict;
    assign o_rsp.queued_count   = QCOUNT_W'(r_out_qcnt);
    assign o_rsp.inflight_count = FCOUNT_W'(r_out_fcnt);
    assign o_rsp.overflow       = r_ovf;
endmodule
`default_nettype wire

// ===== rtl/rac_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hash slot cell
// Holds one stored hash and its valid bit, and passes a search or insert
// token to the next cell each cycle.
// ----------------------------------------------------------------------------
module rac_cell
    import rac_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_clear,
    input  wire logic [HASH_W-1:0] i_key,
    input  wire t_link             i_link,
    output t_link                  o_link
);
    logic              r_valid;
    logic              n_valid;
    logic [HASH_W-1:0] r_key;
    t_link             r_link;
    t_link             n_link;
    logic              wr;
    logic              match;

    assign match = r_valid && (r_key == i_key);

    always_comb begin
        n_link  = i_link;
        n_valid = r_valid;
        wr      = 1'b0;
        if (i_link.go) begin
            if (i_link.ins) begin
                if (!r_valid && !i_link.claim) begin
                    wr           = 1'b1;
                    n_valid      = 1'b1;
                    n_link.claim = 1'b1;
                end
            end else begin
                n_link.hit = i_link.hit | match;
                if (i_link.rm && match) begin
                    n_valid = 1'b0;
                end
            end
        end
        if (i_clear) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_link  <= '0;
        end else begin
            r_valid <= n_valid;
            r_link  <= n_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_key <= i_key;
        end
    end

    assign o_link = r_link;
endmodule
`default_nettype wire
